FILE: src/hkrt_pkg.sv
`timescale 1ns / 1ps

package hkrt_pkg;

	localparam int unsigned POS_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned RUN_W = 8;

	typedef logic [POS_W-1:0] pos_t;

	localparam logic [POS_W:0] LIFT_DISTANCE = 17'd1000;
	localparam logic [POS_W-1:0] FAST_STEP = 16'd100;
	localparam logic [RUN_W-1:0] DIR_RUN_NEEDED = 8'd2;
	localparam logic [POS_W+1:0] REPRESS_EXTRA = 18'd100;
	localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACT_POINT        = 3'd0,
		CFG_ACT_TRIGGER      = 3'd1,
		CFG_RESET_POINT      = 3'd2,
		CFG_RESET_TRIGGER    = 3'd3,
		CFG_STROKE_LENGTH    = 3'd4,
		CFG_ACT_HEIGHT       = 3'd5,
		CFG_ACT_POINT_LOW    = 3'd6,
		CFG_RESET_POINT_HIGH = 3'd7
	} cfg_idx_t;

	localparam pos_t RST_ACT_POINT        = 16'd1500;
	localparam pos_t RST_ACT_TRIGGER      = 16'd300;
	localparam pos_t RST_RESET_POINT      = 16'd500;
	localparam pos_t RST_RESET_TRIGGER    = 16'd300;
	localparam pos_t RST_STROKE_LENGTH    = 16'd4000;
	localparam pos_t RST_ACT_HEIGHT       = 16'd3500;
	localparam pos_t RST_ACT_POINT_LOW    = 16'd300;
	localparam pos_t RST_RESET_POINT_HIGH = 16'd300;

	typedef struct packed {
		pos_t act_point;
		pos_t act_trigger;
		pos_t reset_point;
		pos_t reset_trigger;
		pos_t stroke_length;
		pos_t act_height;
		pos_t act_point_low;
		pos_t reset_point_high;
	} hkrt_cfg_t;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	localparam logic [1:0] STATUS_RELEASED  = 2'd0;
	localparam logic [1:0] STATUS_PRESSED   = 2'd1;
	localparam logic [1:0] STATUS_REMOVED   = 2'd2;
	localparam logic [1:0] STATUS_CANCELING = 2'd3;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_UP   = 2'd2;

	typedef enum logic [3:0] {
		ST_RELEASED  = 4'b0001,
		ST_PRESSED   = 4'b0010,
		ST_REMOVED   = 4'b0100,
		ST_CANCELING = 4'b1000
	} key_fsm_t;

	typedef struct packed {
		logic       kind;
		pos_t       position;
		pos_t       offset;
	} hkrt_item_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [1:0] key_status;
	} hkrt_res_t;

	function automatic logic [1:0] status_code(key_fsm_t s);
		logic [1:0] code;
		case (s)
			ST_RELEASED:  code = STATUS_RELEASED;
			ST_PRESSED:   code = STATUS_PRESSED;
			ST_REMOVED:   code = STATUS_REMOVED;
			ST_CANCELING: code = STATUS_CANCELING;
			default:      code = STATUS_RELEASED;
		endcase
		return code;
	endfunction

endpackage

FILE: src/hkrt_if.sv
`timescale 1ns / 1ps

interface hkrt_in_if;
	import hkrt_pkg::*;
	logic valid;
	logic ready;
	logic kind;
	pos_t position;
	pos_t offset;

	modport source (output valid, output kind, output position, output offset, input ready);
	modport sink (input valid, input kind, input position, input offset, output ready);
endinterface

interface hkrt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [1:0] key_status;

	modport source (output valid, output event_res, output key_status, input ready);
	modport sink (input valid, input event_res, input key_status, output ready);
endinterface

FILE: src/hall_key_rapid_trigger.sv
`timescale 1ns / 1ps

// Rapid-trigger judge for one magnetic key: every input beat is either a position sample or a
// cancel command, and each gives exactly one result beat with the event and the key state after
// it. A beat is registered on entry, judged from that input register against the tracked
// reference and move history, and the result is held in an output register, so one beat per
// cycle is taken unless the output register holds a result that is not yet accepted; that
// back-pressure is the only limit on rate. Thresholds come from eight 16-bit registers on the
// plain write port, written by the user only while the block is idle; the block does not enforce it.
module hall_key_rapid_trigger
	import hkrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	hkrt_in_if.sink              in_ch,
	hkrt_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  pos_t                 cfg_data
);

	hkrt_cfg_t  cfg;
	hkrt_item_t item_s1;
	logic       valid_s1;
	hkrt_res_t  res;
	hkrt_res_t  res_s2;
	logic       valid_s2;
	logic       advance;

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.kind     <= in_ch.kind;
			item_s1.position <= in_ch.position;
			item_s1.offset   <= in_ch.offset;
		end
	end

	hkrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hkrt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.event_res  = res_s2.event_res;
	assign out_ch.key_status = res_s2.key_status;

endmodule

FILE: src/hkrt_cfg.sv
`timescale 1ns / 1ps

module hkrt_cfg
	import hkrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  pos_t                 cfg_data,
	output hkrt_cfg_t            cfg
);

	hkrt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.act_point        <= RST_ACT_POINT;
			cfg_q.act_trigger      <= RST_ACT_TRIGGER;
			cfg_q.reset_point      <= RST_RESET_POINT;
			cfg_q.reset_trigger    <= RST_RESET_TRIGGER;
			cfg_q.stroke_length    <= RST_STROKE_LENGTH;
			cfg_q.act_height       <= RST_ACT_HEIGHT;
			cfg_q.act_point_low    <= RST_ACT_POINT_LOW;
			cfg_q.reset_point_high <= RST_RESET_POINT_HIGH;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ACT_POINT:        cfg_q.act_point        <= cfg_data;
				CFG_ACT_TRIGGER:      cfg_q.act_trigger      <= cfg_data;
				CFG_RESET_POINT:      cfg_q.reset_point      <= cfg_data;
				CFG_RESET_TRIGGER:    cfg_q.reset_trigger    <= cfg_data;
				CFG_STROKE_LENGTH:    cfg_q.stroke_length    <= cfg_data;
				CFG_ACT_HEIGHT:       cfg_q.act_height       <= cfg_data;
				CFG_ACT_POINT_LOW:    cfg_q.act_point_low    <= cfg_data;
				CFG_RESET_POINT_HIGH: cfg_q.reset_point_high <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/hkrt_core.sv
`timescale 1ns / 1ps

module hkrt_core
	import hkrt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  hkrt_item_t item,
	input  hkrt_cfg_t  cfg,
	output hkrt_res_t  res
);

	key_fsm_t         state_q, state_d;
	pos_t             ref_q, ref_d;
	logic             repress_q, repress_d;
	pos_t             prev_q;
	logic             prev_valid_q;
	pos_t             step_d;
	logic [1:0]       dir_q, dir_d;
	logic [RUN_W-1:0] run_q, run_d;
	logic [1:0]       ev;

	pos_t             pos;
	pos_t             off;
	logic [1:0]       d_now;
	logic             filt_down;
	logic             filt_up;
	pos_t             top;
	logic [POS_W:0]   bot;
	logic             z_top;
	logic             z_bot;
	logic [POS_W:0]   press_base;
	logic [POS_W+1:0] th_press;
	logic [POS_W:0]   th_rel;
	logic [POS_W:0]   stroke_lim;
	pos_t             drop;
	pos_t             rise;

	assign pos = item.position;
	assign off = item.offset;

	always_comb begin
		step_d = '0;
		d_now  = DIR_NONE;
		dir_d  = dir_q;
		run_d  = run_q;
		if (!prev_valid_q) begin
			dir_d = DIR_NONE;
			run_d = '0;
		end else begin
			if (pos < prev_q) begin
				step_d = prev_q - pos;
				d_now  = DIR_DOWN;
			end else if (pos > prev_q) begin
				step_d = pos - prev_q;
				d_now  = DIR_UP;
			end
			if (d_now == DIR_NONE) begin
				run_d = '0;
			end else if (dir_q == d_now && run_q != RUN_MAX) begin
				run_d = run_q + RUN_W'(1);
			end else begin
				dir_d = d_now;
				run_d = RUN_W'(1);
			end
		end
	end

	assign filt_down = (step_d > FAST_STEP) || (dir_d == DIR_DOWN && run_d >= DIR_RUN_NEEDED);
	assign filt_up   = (step_d > FAST_STEP) || (dir_d == DIR_UP && run_d >= DIR_RUN_NEEDED);

	assign top   = (cfg.act_height > off) ? cfg.act_height - off : '0;
	assign bot   = {1'b0, cfg.reset_point} + {1'b0, off};
	assign z_top = pos > top;
	assign z_bot = {1'b0, pos} < bot;

	assign press_base = z_top ? ({1'b0, cfg.act_point} + {1'b0, off}) :
		z_bot ? ({1'b0, cfg.act_point_low} + {1'b0, off}) :
		({1'b0, cfg.act_trigger} + {1'b0, off});
	assign th_press = {1'b0, press_base} + (repress_q ? REPRESS_EXTRA : '0);
	assign th_rel = z_top ? ({1'b0, cfg.reset_point_high} + {1'b0, off}) :
		z_bot ? bot : ({1'b0, cfg.reset_trigger} + {1'b0, off});

	assign stroke_lim = {1'b0, cfg.stroke_length} + LIFT_DISTANCE;
	assign drop = ref_q - pos;
	assign rise = pos - ref_q;

	always_comb begin
		state_d   = state_q;
		ref_d     = ref_q;
		repress_d = repress_q;
		ev        = EV_NONE;
		if (item.kind) begin
			if (state_q == ST_PRESSED) begin
				state_d = ST_CANCELING;
			end
		end else begin
			case (state_q)
				ST_CANCELING: begin
					ref_d     = pos;
					repress_d = 1'b1;
					state_d   = ST_RELEASED;
					ev        = EV_RELEASE;
				end
				ST_RELEASED: begin
					if ({1'b0, pos} > stroke_lim) begin
						state_d   = ST_REMOVED;
						ref_d     = cfg.stroke_length;
						repress_d = 1'b0;
					end else if (pos > ref_q) begin
						ref_d = pos;
						if ({1'b0, pos} > bot) begin
							repress_d = 1'b0;
						end
					end else if ({2'b00, drop} > th_press && filt_down) begin
						ref_d     = pos;
						repress_d = 1'b0;
						state_d   = ST_PRESSED;
						ev        = EV_PRESS;
					end
				end
				ST_PRESSED: begin
					if (pos < ref_q) begin
						ref_d = pos;
					end else if ({1'b0, rise} > th_rel && filt_up) begin
						ref_d   = pos;
						state_d = ST_RELEASED;
						ev      = EV_RELEASE;
					end
				end
				default: begin
					if (pos < cfg.stroke_length) begin
						state_d = ST_RELEASED;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RELEASED;
			ref_q        <= '0;
			repress_q    <= 1'b0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			dir_q        <= DIR_NONE;
			run_q        <= '0;
		end else if (advance) begin
			state_q   <= state_d;
			ref_q     <= ref_d;
			repress_q <= repress_d;
			if (!item.kind) begin
				prev_q       <= pos;
				prev_valid_q <= 1'b1;
				dir_q        <= dir_d;
				run_q        <= run_d;
			end
		end
	end

	assign res.event_res  = ev;
	assign res.key_status = status_code(state_d);

`ifndef SYNTH
	a_press_enters_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev == EV_PRESS |=> state_q == ST_PRESSED)
		else $error("press beat did not leave the key pressed");

	a_cancel_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.kind && state_q != ST_PRESSED |=> $stable(state_q))
		else $error("cancel changed the state of a key that was not pressed");

	a_cancel_forces_release: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item.kind && state_q == ST_CANCELING |-> ev == EV_RELEASE)
		else $error("sample after cancel did not release");

	a_run_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		run_q != '0 |-> dir_q != DIR_NONE)
		else $error("run length counted without a direction");

	a_cancel_keeps_motion: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.kind |=> $stable(prev_q) && $stable(run_q) && $stable(dir_q))
		else $error("cancel touched the move history");
`endif

endmodule
